/* rtl/swf_pkg.sv */
// ----------------------------------------------------------------------------
// swf_pkg: shared types, constants and helpers
// Word format, pipeline sizes, register indexes and the divider step used by
// the shallow-water nodal flux pipeline.
// ----------------------------------------------------------------------------
package swf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int CFG_BITS  = 31;
    localparam int KIND_BITS = 2;
    localparam int REG_ADDR_BITS = 1;

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int PR_BITS   = CFG_BITS + 2 * WORD_BITS - 2 * FRAC_BITS - 1;
    localparam int SUM_BITS  = ((PROD_BITS > PR_BITS) ? PROD_BITS : PR_BITS) + 2;

    // two quotient bits per divider stage
    localparam int DIV_STAGES = PROD_BITS / 2;

    localparam int IN_DATA_BITS  = ((4 * WORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((6 * WORD_BITS + 7) / 8) * 8;

    localparam logic [KIND_BITS-1:0] KIND_WET   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FLOOD = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DRY   = 2'd2;

    localparam logic [REG_ADDR_BITS-1:0] REG_DEPTH_THR = 1'd0;
    localparam logic [REG_ADDR_BITS-1:0] REG_GRAVITY   = 1'd1;

    localparam logic [CFG_BITS-1:0] DEPTH_THR_RST = CFG_BITS'(66);
    localparam logic [CFG_BITS-1:0] GRAVITY_RST   = CFG_BITS'(642908);

    typedef struct packed {
        logic [WORD_BITS-1:0] hm;
        logic [PR_BITS-1:0]   pr_mag;
        logic                 pr_neg;
        logic                 xy_neg;
        logic                 zero;
        logic                 wen;
        logic [WORD_BITS-1:0] qx;
        logic [WORD_BITS-1:0] qy;
        logic                 last;
    } t_side;

    typedef struct packed {
        logic [PROD_BITS-1:0] pxx;
        logic [PROD_BITS-1:0] pyy;
        logic [PROD_BITS-1:0] pxy;
        t_side                side;
    } t_mid;

    typedef struct packed {
        logic [WORD_BITS:0]   rem;
        logic [PROD_BITS-1:0] num;
    } t_lane;

    typedef struct packed {
        t_lane xx;
        t_lane yy;
        t_lane xy;
        t_side side;
    } t_dstage;

    typedef struct packed {
        logic                 wen;
        logic [WORD_BITS-1:0] mass_x;
        logic [WORD_BITS-1:0] momx_x;
        logic [WORD_BITS-1:0] momy_x;
        logic [WORD_BITS-1:0] mass_y;
        logic [WORD_BITS-1:0] momx_y;
        logic [WORD_BITS-1:0] momy_y;
        logic                 last;
    } t_res;

    // one restoring division step: shift in a dividend bit, subtract if it fits
    function automatic t_lane div_step(t_lane a, logic [WORD_BITS-1:0] d);
        logic [WORD_BITS:0] rem;
        t_lane              r;
        rem   = {a.rem[WORD_BITS-1:0], a.num[PROD_BITS-1]};
        r.num = {a.num[PROD_BITS-2:0], 1'b0};
        if (rem >= {1'b0, d}) begin
            rem      = rem - {1'b0, d};
            r.num[0] = 1'b1;
        end
        r.rem = rem;
        return r;
    endfunction

    // clamp a wide signed value to the signed word range
    function automatic logic [WORD_BITS-1:0] sat_word(logic signed [SUM_BITS-1:0] v);
        logic [WORD_BITS-1:0] r;
        if (v > $signed({{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}})) begin
            r = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (v < $signed({{(SUM_BITS-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}})) begin
            r = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/swf_front.sv */
// ----------------------------------------------------------------------------
// swf_front: operand split, squares and pressure term
// Five register stages: magnitudes, products, depth/bed difference, partial
// products with gravity, pressure assembly.
// ----------------------------------------------------------------------------
module swf_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic                                 i_vld,
    input  logic [swf_pkg::KIND_BITS-1:0]        i_kind,
    input  logic signed [swf_pkg::WORD_BITS-1:0] i_depth,
    input  logic signed [swf_pkg::WORD_BITS-1:0] i_qx,
    input  logic signed [swf_pkg::WORD_BITS-1:0] i_qy,
    input  logic signed [swf_pkg::WORD_BITS-1:0] i_bed,
    input  logic                                 i_last,
    input  logic [swf_pkg::CFG_BITS-1:0]         i_thr,
    input  logic [swf_pkg::CFG_BITS-1:0]         i_grav,
    output logic                                 o_vld,
    output swf_pkg::t_mid                        o_mid
);
    import swf_pkg::*;

    localparam int W = WORD_BITS;
    localparam int GP_BITS = CFG_BITS + W;

    typedef struct packed {
        logic [W-1:0] hm;
        logic         xy_neg;
        logic         zero;
        logic         wen;
        logic [W-1:0] qx;
        logic [W-1:0] qy;
        logic         last;
    } t_carry;

    logic [4:0] r_vld;

    // stage 1
    t_carry              n_c1, r_c1;
    logic [W-1:0]        n_xm, n_ym, n_zm, r_xm, r_ym, r_zm;
    logic [CFG_BITS-1:0] n_g, r_g1;
    // stage 2
    t_carry              r_c2;
    logic [CFG_BITS-1:0] r_g2;
    logic [PROD_BITS-1:0] r_hh, r_zz, r_pxx2, r_pyy2, r_pxy2;
    // stage 3
    t_carry              r_c3;
    logic [CFG_BITS-1:0] r_g3;
    logic [PROD_BITS-1:0] r_dmag, r_pxx3, r_pyy3, r_pxy3;
    logic                r_dneg3;
    // stage 4
    t_carry              r_c4;
    logic [GP_BITS-1:0]  r_plo, r_phi;
    logic [PROD_BITS-1:0] r_pxx4, r_pyy4, r_pxy4;
    logic                r_dneg4;
    // stage 5
    t_mid                n_mid, r_mid;
    logic [GP_BITS+W-1:0] w_gp;

    always_comb begin
        n_c1.hm     = i_depth[W-1] ? W'(-$unsigned(i_depth)) : $unsigned(i_depth);
        n_xm        = i_qx[W-1]    ? W'(-$unsigned(i_qx))    : $unsigned(i_qx);
        n_ym        = i_qy[W-1]    ? W'(-$unsigned(i_qy))    : $unsigned(i_qy);
        n_zm        = i_bed[W-1]   ? W'(-$unsigned(i_bed))   : $unsigned(i_bed);
        n_c1.xy_neg = i_qx[W-1] ^ i_qy[W-1];
        n_c1.wen    = (i_kind != KIND_DRY);
        n_c1.zero   = (i_kind == KIND_DRY) || i_depth[W-1] ||
                      ({{CFG_BITS{1'b0}}, n_c1.hm} <= {{W{1'b0}}, i_thr});
        n_c1.qx     = $unsigned(i_qx);
        n_c1.qy     = $unsigned(i_qy);
        n_c1.last   = i_last;
        n_g         = (i_kind == KIND_FLOOD) ? '0 : i_grav;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_c1 <= n_c1;
            r_xm <= n_xm;
            r_ym <= n_ym;
            r_zm <= n_zm;
            r_g1 <= n_g;

            r_c2   <= r_c1;
            r_g2   <= r_g1;
            r_hh   <= PROD_BITS'(r_c1.hm) * PROD_BITS'(r_c1.hm);
            r_zz   <= PROD_BITS'(r_zm) * PROD_BITS'(r_zm);
            r_pxx2 <= PROD_BITS'(r_xm) * PROD_BITS'(r_xm);
            r_pyy2 <= PROD_BITS'(r_ym) * PROD_BITS'(r_ym);
            r_pxy2 <= PROD_BITS'(r_xm) * PROD_BITS'(r_ym);

            r_c3    <= r_c2;
            r_g3    <= r_g2;
            r_dneg3 <= (r_hh < r_zz);
            r_dmag  <= (r_hh < r_zz) ? (r_zz - r_hh) : (r_hh - r_zz);
            r_pxx3  <= r_pxx2;
            r_pyy3  <= r_pyy2;
            r_pxy3  <= r_pxy2;

            r_c4    <= r_c3;
            r_dneg4 <= r_dneg3;
            r_plo   <= GP_BITS'(r_g3) * GP_BITS'(r_dmag[W-1:0]);
            r_phi   <= GP_BITS'(r_g3) * GP_BITS'(r_dmag[PROD_BITS-1:W]);
            r_pxx4  <= r_pxx3;
            r_pyy4  <= r_pyy3;
            r_pxy4  <= r_pxy3;

            r_mid <= n_mid;
        end
    end

    // g*|hh-zz| assembled from the two halves, then scaled by 1/2^(2F+1)
    assign w_gp = {r_phi, {W{1'b0}}} + (GP_BITS+W)'(r_plo);

    always_comb begin
        n_mid.pxx         = r_pxx4;
        n_mid.pyy         = r_pyy4;
        n_mid.pxy         = r_pxy4;
        n_mid.side.hm     = r_c4.hm;
        n_mid.side.pr_mag = PR_BITS'(w_gp >> (2 * FRAC_BITS + 1));
        n_mid.side.pr_neg = r_dneg4;
        n_mid.side.xy_neg = r_c4.xy_neg;
        n_mid.side.zero   = r_c4.zero;
        n_mid.side.wen    = r_c4.wen;
        n_mid.side.qx     = r_c4.qx;
        n_mid.side.qy     = r_c4.qy;
        n_mid.side.last   = r_c4.last;
    end

    assign o_vld = r_vld[4];
    assign o_mid = r_mid;

endmodule

/* rtl/swf_div.sv */
// ----------------------------------------------------------------------------
// swf_div: pipelined restoring divider, three lanes
// Divides the three discharge products by the depth, two quotient bits per
// stage, carrying the remaining node fields alongside.
// ----------------------------------------------------------------------------
module swf_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_vld,
    input  swf_pkg::t_mid    i_mid,
    output logic             o_vld,
    output swf_pkg::t_dstage o_st
);
    import swf_pkg::*;

    t_dstage              w_in;
    t_dstage              r_pipe [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vld;

    always_comb begin
        w_in.xx.rem = '0;
        w_in.xx.num = i_mid.pxx;
        w_in.yy.rem = '0;
        w_in.yy.num = i_mid.pyy;
        w_in.xy.rem = '0;
        w_in.xy.num = i_mid.pxy;
        w_in.side   = i_mid.side;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_st
        t_dstage w_prev;
        t_dstage n_stage;
        logic    w_vprev;

        if (k == 0) begin : g_first
            assign w_prev  = w_in;
            assign w_vprev = i_vld;
        end else begin : g_next
            assign w_prev  = r_pipe[k-1];
            assign w_vprev = r_vld[k-1];
        end

        always_comb begin
            n_stage      = w_prev;
            n_stage.xx   = div_step(div_step(w_prev.xx, w_prev.side.hm), w_prev.side.hm);
            n_stage.yy   = div_step(div_step(w_prev.yy, w_prev.side.hm), w_prev.side.hm);
            n_stage.xy   = div_step(div_step(w_prev.xy, w_prev.side.hm), w_prev.side.hm);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= w_vprev;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_pipe[k] <= n_stage;
            end
        end
    end

    assign o_vld = r_vld[DIV_STAGES-1];
    assign o_st  = r_pipe[DIV_STAGES-1];

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_vld && !o_st.side.zero) |->
            (o_st.xx.rem < {1'b0, o_st.side.hm}) && (o_st.xy.rem < {1'b0, o_st.side.hm}))
        else $error("divider remainder not below depth");
`endif

endmodule

/* rtl/swf_post.sv */
// ----------------------------------------------------------------------------
// swf_post: flux assembly
// Adds the pressure term to the velocity products, applies signs, saturates
// and clears the fluxes of dry or shallow nodes.
// ----------------------------------------------------------------------------
module swf_post (
    input  swf_pkg::t_dstage i_st,
    output swf_pkg::t_res    o_res
);
    import swf_pkg::*;

    logic signed [SUM_BITS-1:0] w_pr, w_sx, w_sy, w_xy;
    logic [SUM_BITS-1:0]        w_pr_ext, w_xy_ext;

    assign w_pr_ext = SUM_BITS'(i_st.side.pr_mag);
    assign w_xy_ext = SUM_BITS'(i_st.xy.num);
    assign w_pr = i_st.side.pr_neg ? -$signed(w_pr_ext) : $signed(w_pr_ext);
    assign w_sx = $signed(SUM_BITS'(i_st.xx.num)) + w_pr;
    assign w_sy = $signed(SUM_BITS'(i_st.yy.num)) + w_pr;
    assign w_xy = i_st.side.xy_neg ? -$signed(w_xy_ext) : $signed(w_xy_ext);

    always_comb begin
        o_res.wen  = i_st.side.wen;
        o_res.last = i_st.side.last;
        if (i_st.side.zero) begin
            o_res.mass_x = '0;
            o_res.momx_x = '0;
            o_res.momy_x = '0;
            o_res.mass_y = '0;
            o_res.momx_y = '0;
            o_res.momy_y = '0;
        end else begin
            o_res.mass_x = i_st.side.qx;
            o_res.momx_x = sat_word(w_sx);
            o_res.momy_x = sat_word(w_xy);
            o_res.mass_y = i_st.side.qy;
            o_res.momx_y = sat_word(w_xy);
            o_res.momy_y = sat_word(w_sy);
        end
    end

endmodule

/* rtl/shallow_water_nodal_flux.sv */
// ----------------------------------------------------------------------------
// shallow_water_nodal_flux: 2D shallow-water flux terms for one mesh node
// Throughput: one node per cycle while results are taken; every stage holds
//   while the output register is full and not being taken. The divider
//   advances two quotient bits per stage, so its depth grows with the word
//   width but never its rate.
// Reset: synchronous, active low; clears every valid bit and loads the depth
//   threshold (66) and gravity (642908) registers.
// ----------------------------------------------------------------------------
module shallow_water_nodal_flux (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // input stream
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: depth, discharge_x, discharge_y, bed_elevation
    input  logic [swf_pkg::IN_DATA_BITS-1:0]      i_s_axis_tdata,
    // tuser: region_kind
    input  logic [swf_pkg::KIND_BITS-1:0]         i_s_axis_tuser,
    input  logic                                  i_s_axis_tlast,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // tdata: mass_flux_x, momx_flux_x, momy_flux_x, mass_flux_y, momx_flux_y,
    //        momy_flux_y
    output logic [swf_pkg::OUT_DATA_BITS-1:0]     o_m_axis_tdata,
    // tuser: write_enable
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tlast,
    // configuration writes
    input  logic                                  i_cfg_we,
    input  logic [swf_pkg::REG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [swf_pkg::CFG_BITS-1:0]          i_cfg_wdata
);
    import swf_pkg::*;

    localparam int W = WORD_BITS;

    logic [CFG_BITS-1:0] r_thr, r_grav;
    logic                w_adv;
    logic                w_in_acc;
    logic                w_mid_vld, w_div_vld;
    t_mid                w_mid;
    t_dstage             w_st;
    t_res                w_res, r_res;
    logic                r_out_vld;

    // Configuration registers: to be written only while the pipeline is empty; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= DEPTH_THR_RST;
            r_grav <= GRAVITY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DEPTH_THR: r_thr  <= i_cfg_wdata;
                REG_GRAVITY:   r_grav <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves as one: advance whenever the output register
    // is empty or its result is being taken; otherwise hold every stage.
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign w_in_acc        = i_s_axis_tvalid && w_adv;

    swf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_in_acc),
        .i_kind  (i_s_axis_tuser),
        .i_depth ($signed(i_s_axis_tdata[W-1:0])),
        .i_qx    ($signed(i_s_axis_tdata[2*W-1:W])),
        .i_qy    ($signed(i_s_axis_tdata[3*W-1:2*W])),
        .i_bed   ($signed(i_s_axis_tdata[4*W-1:3*W])),
        .i_last  (i_s_axis_tlast),
        .i_thr   (r_thr),
        .i_grav  (r_grav),
        .o_vld   (w_mid_vld),
        .o_mid   (w_mid)
    );

    swf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_mid_vld),
        .i_mid   (w_mid),
        .o_vld   (w_div_vld),
        .o_st    (w_st)
    );

    swf_post u_post (
        .i_st  (w_st),
        .o_res (w_res)
    );

    // Output register: holds a finished result until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_res.wen;
    assign o_m_axis_tlast  = r_res.last;
    assign o_m_axis_tdata  = OUT_DATA_BITS'({r_res.momy_y, r_res.momx_y, r_res.mass_y,
                                             r_res.momy_x, r_res.momx_x, r_res.mass_x});

`ifndef SYNTHESIS
    a_dry_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("dry-region result carries non-zero fluxes");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

    a_cross_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_res.momy_x == r_res.momx_y))
        else $error("cross momentum fluxes differ");
`endif

endmodule

/* verif/shallow_water_nodal_flux_tb.sv */
// ----------------------------------------------------------------------------
// shallow_water_nodal_flux_tb: self-checking bench for the nodal flux block
// Streams mesh nodes through the block under random source gaps and sink
// stalls, checks each output transaction field by field against a typed-in
// or exact wide-arithmetic result, and changes configuration between phases.
// ----------------------------------------------------------------------------
module shallow_water_nodal_flux_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swf_pkg::*;

    localparam int LATENCY     = 5 + WORD_BITS + 1;
    localparam int CYCLE_LIMIT = 400000;

    // one mesh node as it enters the block
    typedef struct {
        logic [KIND_BITS-1:0]        kind;
        logic signed [WORD_BITS-1:0] h;
        logic signed [WORD_BITS-1:0] qx;
        logic signed [WORD_BITS-1:0] qy;
        logic signed [WORD_BITS-1:0] z;
        logic                        last;
    } t_node;

    // directed row: node plus optional typed-in expectation
    typedef struct {
        t_node node;
        bit    typed;
        t_res  res;
    } t_row;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic [KIND_BITS-1:0]     s_tuser = '0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;
    logic                     m_tlast;
    logic                     cfg_we = 1'b0;
    logic [REG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_BITS-1:0]      cfg_wdata = '0;

    // predictor copy of the two registers
    logic [CFG_BITS-1:0] thr_reg = DEPTH_THR_RST;
    logic [CFG_BITS-1:0] grav_reg = GRAVITY_RST;

    t_res flux_queue[$];
    int   fail_count = 0;
    int   cycles = 0;
    bit   sink_busy = 1'b1;

    shallow_water_nodal_flux dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // clamp an exact value to the signed word range
    function automatic logic [WORD_BITS-1:0] clamp_word(logic signed [199:0] v);
        logic signed [199:0] hi_lim, lo_lim;
        hi_lim = (200'sd1 <<< (WORD_BITS - 1)) - 1;
        lo_lim = -(200'sd1 <<< (WORD_BITS - 1));
        if (v > hi_lim) return hi_lim[WORD_BITS-1:0];
        if (v < lo_lim) return lo_lim[WORD_BITS-1:0];
        return v[WORD_BITS-1:0];
    endfunction

    // exact flux terms for one node; division truncates toward zero
    function automatic t_res node_flux(t_node n);
        t_res r;
        logic signed [199:0] h, qx, qy, z, g, p, xx, yy, xy;
        r = '0;
        r.last = n.last;
        if (n.kind == KIND_DRY) return r;
        r.wen = 1'b1;
        h = n.h; qx = n.qx; qy = n.qy; z = n.z;
        if (h <= $signed({169'd0, thr_reg})) return r;
        g = (n.kind == KIND_FLOOD) ? 200'sd0 : $signed({169'd0, grav_reg});
        p  = (g * (h * h - z * z)) / (200'sd1 <<< (2 * FRAC_BITS + 1));
        xx = (qx * qx) / h;
        yy = (qy * qy) / h;
        xy = (qx * qy) / h;
        r.mass_x = n.qx;
        r.momx_x = clamp_word(xx + p);
        r.momy_x = clamp_word(xy);
        r.mass_y = n.qy;
        r.momx_y = clamp_word(xy);
        r.momy_y = clamp_word(yy + p);
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n) @(posedge clk);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one write, then the port is left quiet before the task returns
    task automatic write_reg(logic [REG_ADDR_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_DEPTH_THR) thr_reg = val;
        else if (idx == REG_GRAVITY) grav_reg = val;
        @(posedge clk);
    endtask

    // drop the source, drain, then let the pipeline settle before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (flux_queue.size() != 0) @(posedge clk);
        idle_cycles(LATENCY + 4);
    endtask

    // present one node and hold it until the block takes it
    task automatic send_node(t_node n, bit typed, t_res want);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            idle_cycles(gap);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {n.z, n.qy, n.qx, n.h};
        s_tuser  <= n.kind;
        s_tlast  <= n.last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        flux_queue.push_back(typed ? want : node_flux(n));
    endtask

    function automatic logic [WORD_BITS-1:0] rand_word(int style);
        case (style)
            0: return $urandom();
            1: return $signed($urandom_range(0, 20000)) - 10000;
            2: return {1'b0, 15'(0), 16'($urandom)} << $urandom_range(0, 8);
            default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    function automatic t_node rand_node();
        t_node n;
        int    s;
        s = $urandom_range(0, 9) < 7 ? 2 : $urandom_range(0, 3);
        n.kind = KIND_BITS'($urandom_range(0, 3));
        n.h    = rand_word(s);
        if ($urandom_range(0, 9) < 7) n.h[WORD_BITS-1] = 1'b0;
        n.qx   = rand_word($urandom_range(0, 3));
        n.qy   = rand_word($urandom_range(0, 3));
        n.z    = rand_word($urandom_range(0, 3));
        n.last = $urandom_range(0, 15) == 0;
        return n;
    endfunction

    // sink: random stalls with calm stretches
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) sink_busy = !sink_busy;
            m_tready <= sink_busy ? (gap_len() == 0) : 1'b1;
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        t_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (flux_queue.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = flux_queue.pop_front();
                if (m_tuser !== want.wen) begin
                    $error("write_enable exp %0d got %0d", want.wen, m_tuser); fail_count++;
                end
                if (m_tdata[0*WORD_BITS +: WORD_BITS] !== want.mass_x) begin
                    $error("mass_flux_x exp %h got %h", want.mass_x,
                           m_tdata[0*WORD_BITS +: WORD_BITS]); fail_count++;
                end
                if (m_tdata[1*WORD_BITS +: WORD_BITS] !== want.momx_x) begin
                    $error("momx_flux_x exp %h got %h", want.momx_x,
                           m_tdata[1*WORD_BITS +: WORD_BITS]); fail_count++;
                end
                if (m_tdata[2*WORD_BITS +: WORD_BITS] !== want.momy_x) begin
                    $error("momy_flux_x exp %h got %h", want.momy_x,
                           m_tdata[2*WORD_BITS +: WORD_BITS]); fail_count++;
                end
                if (m_tdata[3*WORD_BITS +: WORD_BITS] !== want.mass_y) begin
                    $error("mass_flux_y exp %h got %h", want.mass_y,
                           m_tdata[3*WORD_BITS +: WORD_BITS]); fail_count++;
                end
                if (m_tdata[4*WORD_BITS +: WORD_BITS] !== want.momx_y) begin
                    $error("momx_flux_y exp %h got %h", want.momx_y,
                           m_tdata[4*WORD_BITS +: WORD_BITS]); fail_count++;
                end
                if (m_tdata[5*WORD_BITS +: WORD_BITS] !== want.momy_y) begin
                    $error("momy_flux_y exp %h got %h", want.momy_y,
                           m_tdata[5*WORD_BITS +: WORD_BITS]); fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_out exp %0d got %0d", want.last, m_tlast); fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        t_res zero_res;
        logic [CFG_BITS-1:0] thr_set[4];
        logic [CFG_BITS-1:0] grav_set[4];
        int phase;

        idle_cycles(7);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; typed rows only where the answer is obvious
        zero_res = '0;
        row.typed = 1'b0; row.res = zero_res;
        // dry region: nothing written, fluxes zero
        row.node = '{KIND_DRY, 32'sh0001_0000, 32'sh7fff_ffff, -32'sh1, 32'sh5, 1'b1};
        row.typed = 1'b1; row.res = '{1'b0, 0, 0, 0, 0, 0, 0, 1'b1}; rows.push_back(row);
        // depth exactly at threshold and negative depths: written zeros
        row.node = '{KIND_WET, 32'sd66, 32'sh1234, 32'sh4321, 32'sh9, 1'b0};
        row.res = '{1'b1, 0, 0, 0, 0, 0, 0, 1'b0}; rows.push_back(row);
        row.node = '{KIND_FLOOD, 32'sh8000_0000, 32'sh1, 32'sh1, 32'sh1, 1'b0};
        rows.push_back(row);
        row.node = '{2'd3, -32'sd1, -32'sd7, 32'sd7, 32'sd0, 1'b0};
        rows.push_back(row);
        row.typed = 1'b0;
        // just above the threshold, then unit depth under flood, code 3 and wet
        row.node = '{KIND_WET, 32'sd67, 32'sh0001_0000, -32'sh0001_0000, 32'sh2, 1'b0};
        rows.push_back(row);
        row.node = '{KIND_FLOOD, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh4_0000, 1'b1};
        rows.push_back(row);
        row.node = '{2'd3, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh4_0000, 1'b0};
        rows.push_back(row);
        row.node = '{KIND_WET, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 32'sh4_0000, 1'b0};
        rows.push_back(row);
        // extremes: saturation both ways, deepest node, steep bed
        row.node = '{KIND_WET, 32'sd67, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 1'b0};
        rows.push_back(row);
        row.node = '{KIND_WET, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0};
        rows.push_back(row);
        row.node = '{KIND_WET, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh0, 1'b1};
        rows.push_back(row);
        row.node = '{KIND_WET, 32'sh100, 32'sh0, 32'sh0, 32'sh7fff_ffff, 1'b0};
        rows.push_back(row);
        row.node = '{KIND_FLOOD, 32'sh100, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0};
        rows.push_back(row);
        row.node = '{KIND_WET, 32'sh0005_8000, -32'sh0003_1234, 32'sh0002_abcd, -32'sh1_0000, 1'b0};
        rows.push_back(row);
        foreach (rows[i]) send_node(rows[i].node, rows[i].typed, rows[i].res);

        // register phases, extremes included
        thr_set  = '{31'd0, 31'h7fff_ffff, 31'd66, 31'h0001_0000};
        grav_set = '{31'h7fff_ffff, 31'd0, 31'd642908, 31'd1};
        for (phase = 0; phase < 4; phase++) begin
            drain();
            write_reg(REG_DEPTH_THR, thr_set[phase]);
            write_reg(REG_GRAVITY, grav_set[phase]);
            repeat (210) send_node(rand_node(), 1'b0, zero_res);
            // hold the source until the pipeline is empty
            s_tvalid <= 1'b0;
            while (flux_queue.size() != 0) @(posedge clk);
            repeat (2) send_node(rand_node(), 1'b0, zero_res);
        end

        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
